// ----- src/mptm_pkg.sv -----
package mptm_pkg;

    localparam int MAX_SOURCES = 8;
    localparam int MAX_DESTS = 7;
    localparam int SRC_W = $clog2(MAX_SOURCES);
    localparam int SCNT_W = $clog2(MAX_SOURCES + 1);
    localparam int DST_W = $clog2(MAX_DESTS);
    localparam int DCNT_W = $clog2(MAX_DESTS + 1);
    localparam int DEPTH_D = MAX_SOURCES * MAX_DESTS;
    localparam int DADDR_W = $clog2(DEPTH_D);
    localparam int RESULT_LIMIT = 64;
    localparam int RCNT_W = $clog2(RESULT_LIMIT + 1);

    localparam logic [1:0] KIND_ACK = 2'd0;
    localparam logic [1:0] KIND_PAIR = 2'd1;
    localparam logic [1:0] KIND_SRC = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_SRC_FULL = 2'd1;
    localparam logic [1:0] ST_DST_FULL = 2'd2;

    localparam logic [15:0] ET_IPV4 = 16'h0800;
    localparam logic [15:0] ET_IPV6 = 16'h86DD;

    // Counter class of an ethertype: 0 IPv4, 1 IPv6, 2 other.
    function automatic logic [1:0] proto_class(input logic [15:0] et);
        logic [1:0] c;
        begin
            if (et == ET_IPV4)
                c = 2'd0;
            else if (et == ET_IPV6)
                c = 2'd1;
            else
                c = 2'd2;
            return c;
        end
    endfunction

endpackage

// ----- src/mptm_ctr_ram.sv -----
// Counter memory: three 64-bit counters per entry, one read-modify-write unit.
module mptm_ctr_ram #(
    parameter int DEPTH = 8,
    parameter int AW = 3
) (
    input  logic           clk,
    input  logic [AW-1:0]  raddr,
    output logic [191:0]   rdata,
    input  logic           we,
    input  logic [AW-1:0]  waddr,
    input  logic [191:0]   wdata
);

    logic [191:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ----- src/mptm_mac_ram.sv -----
// Key memory for MAC addresses.
module mptm_mac_ram #(
    parameter int DEPTH = 8,
    parameter int AW = 3
) (
    input  logic           clk,
    input  logic [AW-1:0]  raddr,
    output logic [47:0]    rdata,
    input  logic           we,
    input  logic [AW-1:0]  waddr,
    input  logic [47:0]    wdata
);

    logic [47:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ----- src/mac_pair_traffic_matrix_top.sv -----
// MAC pair traffic matrix.
// Command channel: an item is taken when start is high and busy is low.
// action 0 adds byte_count to the source and the source/destination pair
// counters chosen by ethertype; action 1 dumps all records and clears their counters.
// Result channel: each result is shown for one cycle with valid high; the
// receiver cannot stall it, and last marks the final result of an item.
// Timing: one sequencer shares one key comparator and one 64-bit adder.
// The key search reads one stored MAC and then compares it, one stored
// key per pass. An add searches the source keys and then the destination
// keys under that source; a dump walks the pair records of each source
// and then its source record, and an empty dump gives one empty result.
// The final result appears in the cycle after the last busy cycle, with
// busy already low, so the next item may be transferred at the edge that
// takes the final result.
// Reset clears the source count, all destination counts and the dirty
// mark; key and counter memories need no clearing since every entry is
// written when it is appended.
module mac_pair_traffic_matrix_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic          action,
    input  logic [47:0]   src_mac,
    input  logic [47:0]   dst_mac,
    input  logic [15:0]   ethertype,
    input  logic [31:0]   byte_count,
    output logic          valid,
    output logic [1:0]    kind,
    output logic [1:0]    status,
    output logic [47:0]   rec_src_mac,
    output logic [47:0]   rec_dst_mac,
    output logic [63:0]   bytes_ipv4,
    output logic [63:0]   bytes_ipv6,
    output logic [63:0]   bytes_other,
    output logic          dirty_mark,
    output logic          last
);

    typedef enum logic [3:0] {
        IDLE, S_RD, S_CMP, S_RMW, D_RD, D_CMP, D_RMW, ACK,
        P_SRC, P_DRD, P_DOUT, P_SOUT, P_EMPTY
    } state_t;

    state_t state_reg;
    logic [mptm_pkg::SCNT_W-1:0] scount_reg;
    logic [mptm_pkg::DCNT_W-1:0] dcount_reg [mptm_pkg::MAX_SOURCES];
    logic dirty_reg;
    logic [mptm_pkg::SCNT_W-1:0] s_reg;
    logic [mptm_pkg::DCNT_W-1:0] d_reg;
    logic [mptm_pkg::RCNT_W-1:0] k_reg;
    logic [47:0] smac_reg, dmac_reg;
    logic [1:0] cls_reg;
    logic [31:0] bytes_reg;
    logic [1:0] stat_reg;

    // Memory ports.
    logic [mptm_pkg::SRC_W-1:0] sidx;
    logic [mptm_pkg::DADDR_W-1:0] didx;
    logic [47:0] smac_rd, dmac_rd;
    logic [191:0] sctr_rd, dctr_rd, sctr_wd, dctr_wd;
    logic smac_we, dmac_we, sctr_we, dctr_we;
    logic [47:0] key_rd;
    logic key_hit;
    logic [191:0] upd_in, upd_out;
    logic [63:0] lane_sum;
    logic new_entry;

    assign sidx = s_reg[mptm_pkg::SRC_W-1:0];
    assign didx = mptm_pkg::DADDR_W'(
        32'(sidx) * 32'(mptm_pkg::MAX_DESTS) + 32'(d_reg));

    mptm_mac_ram #(.DEPTH(mptm_pkg::MAX_SOURCES), .AW(mptm_pkg::SRC_W)) u_smac (
        .clk(clk), .raddr(sidx), .rdata(smac_rd),
        .we(smac_we), .waddr(sidx), .wdata(smac_reg));
    mptm_mac_ram #(.DEPTH(mptm_pkg::DEPTH_D), .AW(mptm_pkg::DADDR_W)) u_dmac (
        .clk(clk), .raddr(didx), .rdata(dmac_rd),
        .we(dmac_we), .waddr(didx), .wdata(dmac_reg));
    mptm_ctr_ram #(.DEPTH(mptm_pkg::MAX_SOURCES), .AW(mptm_pkg::SRC_W)) u_sctr (
        .clk(clk), .raddr(sidx), .rdata(sctr_rd),
        .we(sctr_we), .waddr(sidx), .wdata(sctr_wd));
    mptm_ctr_ram #(.DEPTH(mptm_pkg::DEPTH_D), .AW(mptm_pkg::DADDR_W)) u_dctr (
        .clk(clk), .raddr(didx), .rdata(dctr_rd),
        .we(dctr_we), .waddr(didx), .wdata(dctr_wd));

    // Shared key comparator.
    assign key_rd = (state_reg == S_CMP) ? smac_rd : dmac_rd;
    assign key_hit = (key_rd == ((state_reg == S_CMP) ? smac_reg : dmac_reg));

    // Shared counter adder: a fresh entry starts from zero.
    assign new_entry = (state_reg == S_RMW) ? (s_reg == scount_reg)
                                            : (d_reg == dcount_reg[sidx]);
    assign upd_in = new_entry ? 192'd0
                  : ((state_reg == S_RMW) ? sctr_rd : dctr_rd);
    assign lane_sum = upd_in[64*cls_reg +: 64] + 64'(bytes_reg);
    always_comb
    begin
        upd_out = upd_in;
        upd_out[64*cls_reg +: 64] = lane_sum;
    end

    assign smac_we = (state_reg == S_RMW) && new_entry;
    assign sctr_we = (state_reg == S_RMW) || (state_reg == P_SOUT);
    assign sctr_wd = (state_reg == S_RMW) ? upd_out : 192'd0;
    assign dmac_we = (state_reg == D_RMW) && new_entry;
    assign dctr_we = (state_reg == D_RMW) || (state_reg == P_DOUT);
    assign dctr_wd = (state_reg == D_RMW) ? upd_out : 192'd0;

    assign busy = (state_reg != IDLE);

    // Sequencer with its registered result outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            scount_reg <= '0;
            for (int i = 0; i < mptm_pkg::MAX_SOURCES; i++)
                dcount_reg[i] <= '0;
            dirty_reg <= 1'b0;
            s_reg <= '0;
            d_reg <= '0;
            k_reg <= '0;
            valid <= 1'b0;
            last <= 1'b0;
            smac_reg <= '0; dmac_reg <= '0; cls_reg <= '0; bytes_reg <= '0;
            stat_reg <= '0;
            kind <= '0; status <= '0; rec_src_mac <= '0; rec_dst_mac <= '0;
            bytes_ipv4 <= '0; bytes_ipv6 <= '0; bytes_other <= '0;
            dirty_mark <= 1'b0;
        end
        else
        begin
            valid <= 1'b0;
            last <= 1'b0;
            unique case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        smac_reg <= src_mac;
                        dmac_reg <= dst_mac;
                        cls_reg <= mptm_pkg::proto_class(ethertype);
                        bytes_reg <= byte_count;
                        stat_reg <= mptm_pkg::ST_OK;
                        s_reg <= '0;
                        d_reg <= '0;
                        k_reg <= '0;
                        if (action)
                        begin
                            dirty_reg <= 1'b0;
                            state_reg <= (scount_reg == '0) ? P_EMPTY : P_SRC;
                        end
                        else
                            state_reg <= S_RD;
                    end
                end
                // Source search: one stored key per pass.
                S_RD:
                begin
                    if (s_reg == scount_reg)
                    begin
                        if (scount_reg == mptm_pkg::SCNT_W'(mptm_pkg::MAX_SOURCES))
                        begin
                            stat_reg <= mptm_pkg::ST_SRC_FULL;
                            state_reg <= ACK;
                        end
                        else
                            state_reg <= S_RMW;
                    end
                    else
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (key_hit)
                        state_reg <= S_RMW;
                    else
                    begin
                        s_reg <= s_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_RMW:
                begin
                    if (new_entry)
                    begin
                        scount_reg <= scount_reg + 1'b1;
                        dcount_reg[sidx] <= '0;
                    end
                    dirty_reg <= 1'b1;
                    state_reg <= D_RD;
                end
                // Destination search under the chosen source.
                D_RD:
                begin
                    if (d_reg == dcount_reg[sidx])
                    begin
                        if (d_reg == mptm_pkg::DCNT_W'(mptm_pkg::MAX_DESTS))
                        begin
                            stat_reg <= mptm_pkg::ST_DST_FULL;
                            state_reg <= ACK;
                        end
                        else
                            state_reg <= D_RMW;
                    end
                    else
                        state_reg <= D_CMP;
                end
                D_CMP:
                begin
                    if (key_hit)
                        state_reg <= D_RMW;
                    else
                    begin
                        d_reg <= d_reg + 1'b1;
                        state_reg <= D_RD;
                    end
                end
                D_RMW:
                begin
                    if (new_entry)
                        dcount_reg[sidx] <= dcount_reg[sidx] + 1'b1;
                    state_reg <= ACK;
                end
                ACK:
                begin
                    valid <= 1'b1;
                    last <= 1'b1;
                    kind <= mptm_pkg::KIND_ACK;
                    status <= stat_reg;
                    rec_src_mac <= smac_reg;
                    rec_dst_mac <= '0;
                    bytes_ipv4 <= '0; bytes_ipv6 <= '0; bytes_other <= '0;
                    dirty_mark <= dirty_reg;
                    state_reg <= IDLE;
                end
                // Dump walk: destinations of each source, then the source.
                P_SRC:
                begin
                    d_reg <= '0;
                    state_reg <= P_DRD;
                end
                P_DRD:
                begin
                    state_reg <= (d_reg == dcount_reg[sidx]) ? P_SOUT : P_DOUT;
                end
                P_DOUT:
                begin
                    if (k_reg != mptm_pkg::RCNT_W'(mptm_pkg::RESULT_LIMIT))
                    begin
                        valid <= 1'b1;
                        kind <= mptm_pkg::KIND_PAIR;
                        status <= mptm_pkg::ST_OK;
                        rec_src_mac <= smac_rd;
                        rec_dst_mac <= dmac_rd;
                        bytes_ipv4 <= dctr_rd[63:0];
                        bytes_ipv6 <= dctr_rd[127:64];
                        bytes_other <= dctr_rd[191:128];
                        dirty_mark <= dirty_reg;
                        k_reg <= k_reg + 1'b1;
                    end
                    d_reg <= d_reg + 1'b1;
                    state_reg <= P_DRD;
                end
                P_SOUT:
                begin
                    if (k_reg != mptm_pkg::RCNT_W'(mptm_pkg::RESULT_LIMIT))
                    begin
                        valid <= 1'b1;
                        kind <= mptm_pkg::KIND_SRC;
                        status <= mptm_pkg::ST_OK;
                        rec_src_mac <= smac_rd;
                        rec_dst_mac <= '0;
                        bytes_ipv4 <= sctr_rd[63:0];
                        bytes_ipv6 <= sctr_rd[127:64];
                        bytes_other <= sctr_rd[191:128];
                        dirty_mark <= dirty_reg;
                        k_reg <= k_reg + 1'b1;
                        last <= (s_reg + 1'b1 == scount_reg)
                             || (k_reg + 1'b1 == mptm_pkg::RCNT_W'(mptm_pkg::RESULT_LIMIT));
                    end
                    if (s_reg + 1'b1 == scount_reg)
                        state_reg <= IDLE;
                    else
                    begin
                        s_reg <= s_reg + 1'b1;
                        state_reg <= P_SRC;
                    end
                end
                P_EMPTY:
                begin
                    valid <= 1'b1;
                    last <= 1'b1;
                    kind <= mptm_pkg::KIND_EMPTY;
                    status <= mptm_pkg::ST_OK;
                    rec_src_mac <= '0; rec_dst_mac <= '0;
                    bytes_ipv4 <= '0; bytes_ipv6 <= '0; bytes_other <= '0;
                    dirty_mark <= dirty_reg;
                    state_reg <= IDLE;
                end
                default:
                    state_reg <= IDLE;
            endcase
        end
    end

endmodule

// ----- src/mptm_checker.sv -----
// Port-level checks on the traffic matrix.
module mptm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        valid,
    input logic [1:0]  kind,
    input logic [1:0]  status,
    input logic [47:0] rec_dst_mac,
    input logic        dirty_mark,
    input logic        last
);

    // An accepted item always makes the block busy.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("item accepted but not busy");

    // The block is already free while its final result is shown.
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last) |-> !busy) else $error("busy during final result");

    // Dump records carry a clear dirty mark and ok status.
    a_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && kind != mptm_pkg::KIND_ACK) |-> (!dirty_mark && status == mptm_pkg::ST_OK))
        else $error("bad dump record");

    // Acknowledges are single final results with no destination.
    a_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && kind == mptm_pkg::KIND_ACK) |-> (last && rec_dst_mac == 48'd0))
        else $error("bad acknowledge");

endmodule

bind mac_pair_traffic_matrix_top mptm_checker u_mptm_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .valid(valid), .kind(kind), .status(status), .rec_dst_mac(rec_dst_mac),
    .dirty_mark(dirty_mark), .last(last));

// ----- dv/testbench.sv -----
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [47:0] smac;
        logic [47:0] dmac;
        logic [63:0] v4;
        logic [63:0] v6;
        logic [63:0] oth;
        logic        dirty;
        logic        last;
    } record_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        action = 1'b0;
    logic [47:0] src_mac = '0;
    logic [47:0] dst_mac = '0;
    logic [15:0] ethertype = '0;
    logic [31:0] byte_count = '0;
    logic        valid;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [47:0] rec_src_mac;
    logic [47:0] rec_dst_mac;
    logic [63:0] bytes_ipv4;
    logic [63:0] bytes_ipv6;
    logic [63:0] bytes_other;
    logic        dirty_mark;
    logic        last;

    // Matrix mirror: source and destination keys with their counters.
    int          nsrc;
    logic [47:0] smacs [mptm_pkg::MAX_SOURCES];
    logic [63:0] sctr [mptm_pkg::MAX_SOURCES][3];
    int          ndst [mptm_pkg::MAX_SOURCES];
    logic [47:0] dmacs [mptm_pkg::MAX_SOURCES][mptm_pkg::MAX_DESTS];
    logic [63:0] dctr [mptm_pkg::MAX_SOURCES][mptm_pkg::MAX_DESTS][3];
    logic        dirty;

    record_t     expected_records[$];
    int          failures = 0;
    int          send_idle_pct = 0;

    // Small key pools so that lookups hit stored entries often.
    logic [47:0] src_pool [12];
    logic [47:0] dst_pool [10];

    mac_pair_traffic_matrix_top dut (.*);

    always #10 clk = ~clk;

    function automatic int class_of(logic [15:0] et);
        if (et == mptm_pkg::ET_IPV4) return 0;
        if (et == mptm_pkg::ET_IPV6) return 1;
        return 2;
    endfunction

    function automatic record_t mk(logic [1:0] k, logic [1:0] st, logic [47:0] s,
                                   logic [47:0] d, logic [63:0] a, logic [63:0] b,
                                   logic [63:0] c, logic l);
        record_t r;
        r.kind = k; r.status = st; r.smac = s; r.dmac = d;
        r.v4 = a; r.v6 = b; r.oth = c; r.dirty = dirty; r.last = l;
        return r;
    endfunction

    // Work out the records that one item causes and update the mirror.
    task automatic predict_matrix(logic act, logic [47:0] s, logic [47:0] d,
                                  logic [15:0] et, logic [31:0] n);
        int si;
        int di;
        int c;
        int k;
        record_t r;
        c = class_of(et);
        if (!act) begin
            for (si = 0; si < nsrc; si++)
                if (smacs[si] == s) break;
            if (si == nsrc && nsrc >= mptm_pkg::MAX_SOURCES) begin
                expected_records.push_back(mk(mptm_pkg::KIND_ACK, mptm_pkg::ST_SRC_FULL,
                    s, '0, '0, '0, '0, 1'b1));
                return;
            end
            if (si == nsrc) begin
                smacs[si] = s;
                sctr[si] = '{default: '0};
                ndst[si] = 0;
                nsrc++;
            end
            sctr[si][c] += 64'(n);
            for (di = 0; di < ndst[si]; di++)
                if (dmacs[si][di] == d) break;
            dirty = 1'b1;
            if (di == ndst[si] && ndst[si] >= mptm_pkg::MAX_DESTS) begin
                expected_records.push_back(mk(mptm_pkg::KIND_ACK, mptm_pkg::ST_DST_FULL,
                    s, '0, '0, '0, '0, 1'b1));
                return;
            end
            if (di == ndst[si]) begin
                dmacs[si][di] = d;
                dctr[si][di] = '{default: '0};
                ndst[si]++;
            end
            dctr[si][di][c] += 64'(n);
            expected_records.push_back(mk(mptm_pkg::KIND_ACK, mptm_pkg::ST_OK,
                s, '0, '0, '0, '0, 1'b1));
            return;
        end
        dirty = 1'b0;
        if (nsrc == 0) begin
            expected_records.push_back(mk(mptm_pkg::KIND_EMPTY, mptm_pkg::ST_OK,
                '0, '0, '0, '0, '0, 1'b1));
            return;
        end
        k = 0;
        for (si = 0; si < nsrc; si++) begin
            for (di = 0; di < ndst[si]; di++) begin
                if (k < mptm_pkg::RESULT_LIMIT) begin
                    expected_records.push_back(mk(mptm_pkg::KIND_PAIR, mptm_pkg::ST_OK,
                        smacs[si], dmacs[si][di],
                        dctr[si][di][0], dctr[si][di][1], dctr[si][di][2], 1'b0));
                    k++;
                end
                dctr[si][di] = '{default: '0};
            end
            if (k < mptm_pkg::RESULT_LIMIT) begin
                expected_records.push_back(mk(mptm_pkg::KIND_SRC, mptm_pkg::ST_OK,
                    smacs[si], '0, sctr[si][0], sctr[si][1], sctr[si][2], 1'b0));
                k++;
            end
            sctr[si] = '{default: '0};
        end
        r = expected_records.pop_back();
        r.last = 1'b1;
        expected_records.push_back(r);
    endtask

    // Present one item at the falling edge and hold it until the block takes it.
    task automatic send_item(logic act, logic [47:0] s, logic [47:0] d,
                             logic [15:0] et, logic [31:0] n);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        action <= act;
        src_mac <= s;
        dst_mac <= d;
        ethertype <= et;
        byte_count <= n;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_matrix(act, s, d, et, n);
        @(negedge clk);
    endtask

    task automatic add_flow(logic [47:0] s, logic [47:0] d, logic [15:0] et,
                            logic [31:0] n);
        send_item(1'b0, s, d, et, n);
    endtask

    task automatic dump_matrix();
        send_item(1'b1, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                  16'($urandom), $urandom);
    endtask

    function automatic logic [15:0] pick_ethertype();
        case ($urandom_range(3))
            0: return mptm_pkg::ET_IPV4;
            1: return mptm_pkg::ET_IPV6;
            2: return 16'($urandom);
            default: return 16'h86DC;
        endcase
    endfunction

    // Check every result transfer against the oldest expectation.
    always @(posedge clk) begin
        record_t e;
        if (rst_n && valid) begin
            if (expected_records.size() == 0) begin
                $error("unexpected result transfer, kind %0d", kind);
                failures++;
            end
            else begin
                e = expected_records.pop_front();
                if (kind !== e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, kind); failures++;
                end
                if (status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, status); failures++;
                end
                if (rec_src_mac !== e.smac) begin
                    $error("rec_src_mac: expected %h, got %h", e.smac, rec_src_mac);
                    failures++;
                end
                if (rec_dst_mac !== e.dmac) begin
                    $error("rec_dst_mac: expected %h, got %h", e.dmac, rec_dst_mac);
                    failures++;
                end
                if (bytes_ipv4 !== e.v4) begin
                    $error("bytes_ipv4: expected %h, got %h", e.v4, bytes_ipv4); failures++;
                end
                if (bytes_ipv6 !== e.v6) begin
                    $error("bytes_ipv6: expected %h, got %h", e.v6, bytes_ipv6); failures++;
                end
                if (bytes_other !== e.oth) begin
                    $error("bytes_other: expected %h, got %h", e.oth, bytes_other);
                    failures++;
                end
                if (dirty_mark !== e.dirty) begin
                    $error("dirty_mark: expected %0d, got %0d", e.dirty, dirty_mark);
                    failures++;
                end
                if (last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, last); failures++;
                end
            end
        end
    end

    // Empty dump, field extremes and ethertype classes.
    task automatic test_directed();
        dump_matrix();
        add_flow('1, '1, mptm_pkg::ET_IPV4, '1);
        add_flow('1, '1, mptm_pkg::ET_IPV4, '1);
        add_flow('1, '0, mptm_pkg::ET_IPV6, '1);
        add_flow('0, '1, 16'hFFFF, 32'd0);
        add_flow('0, '0, 16'h0000, 32'h5555_AAAA);
        add_flow(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 16'hAAAA, 32'hAAAA_5555);
        dump_matrix();
        dump_matrix();
    endtask

    // Fill one destination table and then the source table past their limits.
    task automatic test_table_limits();
        int i;
        for (i = 0; i < mptm_pkg::MAX_DESTS + 2; i++)
            add_flow(src_pool[0], 48'h0200_0000_0000 + 48'(i), pick_ethertype(), $urandom);
        for (i = 0; i < mptm_pkg::MAX_SOURCES + 2; i++)
            add_flow(48'h0400_0000_0000 + 48'(i), dst_pool[0], pick_ethertype(), $urandom);
        dump_matrix();
    endtask

    // Mostly adds over a small key set, with occasional dumps and wild keys.
    task automatic test_random(int count);
        int i;
        logic [47:0] s;
        logic [47:0] d;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(19) == 0)
                dump_matrix();
            else begin
                s = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom})
                                             : src_pool[$urandom_range(11)];
                d = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom})
                                             : dst_pool[$urandom_range(9)];
                add_flow(s, d, pick_ethertype(), ($urandom_range(3) == 0) ? '1 : $urandom);
            end
        end
        dump_matrix();
    endtask

    initial begin
        int w;
        nsrc = 0;
        dirty = 1'b0;
        foreach (ndst[i]) ndst[i] = 0;
        foreach (src_pool[i]) src_pool[i] = 48'({$urandom, $urandom});
        foreach (dst_pool[i]) dst_pool[i] = 48'({$urandom, $urandom});
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_table_limits();
        send_idle_pct = 29;
        test_random(160);
        send_idle_pct = 67;
        test_random(160);
        send_idle_pct = 0;
        test_random(160);
        start <= 1'b0;

        w = 0;
        while (expected_records.size() != 0 && w < 10000) begin
            @(posedge clk);
            w++;
        end
        repeat (200) @(posedge clk);
        if (failures == 0 && expected_records.size() == 0)
            $display("mac_pair_traffic_matrix_top regression: pass");
        else
            $display("mac_pair_traffic_matrix_top regression: fail");
        $finish;
    end

    // Timeout well above the slowest correct run.
    initial begin
        #20ms;
        $display("mac_pair_traffic_matrix_top regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/mptm_pkg.sv
src/mptm_ctr_ram.sv
src/mptm_mac_ram.sv
src/mac_pair_traffic_matrix_top.sv
src/mptm_checker.sv
dv/testbench.sv
